[rtl/pchih_pkg.sv]
// Package for the per-channel hit interval histogram.
// Holds sizes, register indexes, opcodes, word types and small helpers.
// No dependencies.
`default_nettype none

package pchih_pkg;

	localparam int NUM_CHANNELS = 128;
	localparam int CH_W         = 7;
	localparam int MAX_BINS     = 1024;
	localparam int HIST_DEPTH   = MAX_BINS + 1;
	localparam int BIN_AW       = $clog2(HIST_DEPTH);
	localparam int QUOT_W       = $clog2(MAX_BINS);
	localparam int QBIT_W       = $clog2(QUOT_W);
	localparam int TIME_W       = 31;
	localparam int EVT_W        = 32;
	localparam int CNT_W        = 32;
	localparam int BW_W         = 21;
	localparam int NB_W         = 11;
	localparam int CFG_W        = 21;
	localparam int CFG_IDX_W    = 1;
	localparam int CHAN_W       = TIME_W + EVT_W;

	localparam logic [TIME_W-1:0] WRAP_NS    = 31'd1677721600;
	localparam int                TICK_NS    = 25;
	localparam int                FINE_STEPS = 1024;

	localparam logic [BW_W-1:0] BW_RESET   = 21'd200;
	localparam logic [NB_W-1:0] BINS_RESET = 11'd1000;

	localparam logic [CFG_IDX_W-1:0] REG_BIN_WIDTH   = 1'd0;
	localparam logic [CFG_IDX_W-1:0] REG_BINS_IN_USE = 1'd1;

	localparam logic OP_HIT  = 1'b0;
	localparam logic OP_READ = 1'b1;

	typedef struct packed {
		logic            op;
		logic [CH_W-1:0] channel;
		logic [31:0]     event_id;
		logic [25:0]     coarse_tick;
		logic [9:0]      fine_code;
		logic [10:0]     read_bin;
	} in_word_t;

	typedef struct packed {
		logic [30:0] interval_ns;
		logic        interval_valid;
		logic        filled;
		logic        wrapped;
		logic [31:0] bin_count;
		logic [31:0] hit_total;
		logic [31:0] wrap_total;
	} out_word_t;

	function automatic logic [CNT_W-1:0] sat_inc(input logic [CNT_W-1:0] v);
		return (v == {CNT_W{1'b1}}) ? v : v + 1'b1;
	endfunction

endpackage

`default_nettype wire

[rtl/pchih_ram.sv]
// Generic simple dual-port RAM: one write port, one read port, registered read.
// Standalone; used for the channel table and the histogram.
`default_nettype none

module pchih_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 128,
	localparam int AW   = $clog2(DEPTH)
) (
	input  wire logic             clk,
	input  wire logic             we,
	input  wire logic [AW-1:0]    waddr,
	input  wire logic [WIDTH-1:0] wdata,
	input  wire logic [AW-1:0]    raddr,
	output logic      [WIDTH-1:0] rdata
);

	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end

endmodule

`default_nettype wire

[rtl/per_channel_hit_interval_histogram.sv]
// Per-channel hit interval histogram, top level.
// Depends on pchih_pkg and pchih_ram.
//
// Each hit word is turned into a ns timestamp (coarse*25 + fine correction) and
// compared with the last timestamp of its channel; the interval, wrap-corrected,
// is binned into a 1025-entry histogram (1024 linear bins plus overflow) when
// the channel had an earlier hit and the event ID changed. One word is processed
// at a time. After reset the block runs a clearing pass over all 1025 histogram
// RAM entries and stalls input during that time. Afterwards a bin read passes
// the read and result states; a hit passes stamp, diff and result, and a binned
// hit gets its bin index from a bit-serial divider (one quotient bit per cycle)
// and a read-modify-write of the histogram RAM. The output word has its own
// register, so the next input word is taken while a result waits.
`default_nettype none

module per_channel_hit_interval_histogram
	import pchih_pkg::*;
(
	input  wire logic                 clk,
	input  wire logic                 arst_n,
	input  wire logic                 cfg_we,
	input  wire logic [CFG_IDX_W-1:0] cfg_index,
	input  wire logic [CFG_W-1:0]     cfg_data,
	input  wire logic                 in_valid,
	output logic                      in_stall,
	input  wire in_word_t             in_word,
	output logic                      out_valid,
	input  wire logic                 out_stall,
	output out_word_t                 out_word
);

	typedef enum logic [8:0] {
		S_CLEAR  = 9'b000000001,
		S_IDLE   = 9'b000000010,
		S_READ   = 9'b000000100,
		S_STAMP  = 9'b000001000,
		S_DIFF   = 9'b000010000,
		S_DIV    = 9'b000100000,
		S_HRD    = 9'b001000000,
		S_HWR    = 9'b010000000,
		S_RESULT = 9'b100000000
	} state_t;

	state_t state_q;

	logic [BW_W-1:0]   bw_q;
	logic [NB_W-1:0]   bins_q;
	logic [CNT_W-1:0]  lim_q;
	logic [BIN_AW-1:0] clr_q;
	logic [NUM_CHANNELS-1:0] seen_q;

	in_word_t          item_q;
	logic              rd_ok_q;
	logic [TIME_W-1:0] t_q;
	logic [TIME_W-1:0] prev_t_q;
	logic [EVT_W-1:0]  prev_evt_q;
	logic              seen_hit_q;
	logic [TIME_W-1:0] rem_q;
	logic [QUOT_W-1:0] quot_q;
	logic [QBIT_W-1:0] bit_q;
	logic [BIN_AW-1:0] bin_q;

	logic [TIME_W-1:0] ivl_q;
	logic              valid_q;
	logic              filled_q;
	logic              wrapped_q;
	logic [CNT_W-1:0]  count_q;
	logic [CNT_W-1:0]  hit_cnt_q;
	logic [CNT_W-1:0]  wrap_cnt_q;
	logic              out_valid_q;
	out_word_t         out_word_q;

	// configuration derived values
	logic [BW_W-1:0] w_eff;
	logic [NB_W-1:0] nb_eff;
	assign w_eff  = (bw_q == '0) ? BW_W'(1) : bw_q;
	assign nb_eff = (bins_q > NB_W'(MAX_BINS)) ? NB_W'(MAX_BINS) : bins_q;

	// timestamp
	logic [10:0]       fine_inv;
	logic [15:0]       frac_prod;
	logic [TIME_W-1:0] coarse_ns;
	logic [TIME_W-1:0] t_new;
	assign fine_inv  = 11'(FINE_STEPS) - {1'b0, item_q.fine_code};
	assign frac_prod = 16'(fine_inv) * 16'(TICK_NS);
	assign coarse_ns = 31'(item_q.coarse_tick) * 31'(TICK_NS);
	assign t_new     = coarse_ns + 31'(frac_prod[15:10]);

	// interval
	logic              t_gt;
	logic              t_lt;
	logic [31:0]       wrap_ivl;
	logic [TIME_W-1:0] ivl_new;
	assign t_gt     = t_q > prev_t_q;
	assign t_lt     = t_q < prev_t_q;
	assign wrap_ivl = 32'(WRAP_NS) - (32'(prev_t_q) - 32'(t_q));
	assign ivl_new  = t_gt ? (t_q - prev_t_q) : (t_lt ? wrap_ivl[TIME_W-1:0] : '0);

	// divider step
	logic [TIME_W-1:0] dshift;
	logic [TIME_W:0]   trial;
	assign dshift = TIME_W'(w_eff) << bit_q;
	assign trial  = {1'b0, rem_q} - {1'b0, dshift};

	logic              ovf;
	logic [BIN_AW-1:0] bin_addr;
	assign ovf      = {1'b0, ivl_q} >= lim_q;
	assign bin_addr = ovf ? BIN_AW'(MAX_BINS) : BIN_AW'(quot_q);

	// memories
	logic [CHAN_W-1:0] chan_rdata;
	logic              hist_we;
	logic [BIN_AW-1:0] hist_waddr;
	logic [CNT_W-1:0]  hist_wdata;
	logic [BIN_AW-1:0] hist_raddr;
	logic [CNT_W-1:0]  hist_rdata;
	logic              rbin_ok;

	assign rbin_ok = in_word.read_bin <= 11'(MAX_BINS);

	pchih_ram #(.WIDTH(CHAN_W), .DEPTH(NUM_CHANNELS)) u_chan_ram (
		.clk   (clk),
		.we    (state_q == S_STAMP),
		.waddr (item_q.channel),
		.wdata ({t_new, item_q.event_id}),
		.raddr (in_word.channel),
		.rdata (chan_rdata)
	);

	always_comb begin
		hist_we    = 1'b0;
		hist_waddr = bin_q;
		hist_wdata = sat_inc(hist_rdata);
		case (state_q)
			S_CLEAR: begin
				hist_we    = 1'b1;
				hist_waddr = clr_q;
				hist_wdata = '0;
			end
			S_HWR: begin
				hist_we = 1'b1;
			end
			default: begin
				hist_we = 1'b0;
			end
		endcase
		hist_raddr = (state_q == S_HRD) ? bin_addr
		           : (rbin_ok ? BIN_AW'(in_word.read_bin) : '0);
	end

	pchih_ram #(.WIDTH(CNT_W), .DEPTH(HIST_DEPTH)) u_hist_ram (
		.clk   (clk),
		.we    (hist_we),
		.waddr (hist_waddr),
		.wdata (hist_wdata),
		.raddr (hist_raddr),
		.rdata (hist_rdata)
	);

	logic accept;
	logic ch_ok;
	logic out_free;
	assign in_stall = (state_q != S_IDLE);
	assign accept   = in_valid && !in_stall;
	assign ch_ok    = {1'b0, in_word.channel} < 8'(NUM_CHANNELS);
	assign out_free = !out_valid_q || !out_stall;

	// configuration and bin limit
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			bw_q   <= BW_RESET;
			bins_q <= BINS_RESET;
			lim_q  <= '0;
		end else begin
			if (cfg_we) begin
				case (cfg_index)
					REG_BIN_WIDTH:   bw_q   <= cfg_data;
					REG_BINS_IN_USE: bins_q <= cfg_data[NB_W-1:0];
					default: ;
				endcase
			end
			lim_q <= 32'(nb_eff) * 32'(w_eff);
		end
	end

	// control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_CLEAR;
			clr_q       <= '0;
			seen_q      <= '0;
			hit_cnt_q   <= '0;
			wrap_cnt_q  <= '0;
			out_valid_q <= 1'b0;
			bit_q       <= '0;
		end else begin
			if ((state_q == S_RESULT) && out_free) begin
				out_valid_q <= 1'b1;
			end else if (!out_stall) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				S_CLEAR: begin
					clr_q <= clr_q + 1'b1;
					if (clr_q == BIN_AW'(MAX_BINS)) begin
						state_q <= S_IDLE;
					end
				end
				S_IDLE: begin
					if (accept) begin
						if (in_word.op == OP_READ) begin
							state_q <= S_READ;
						end else if (ch_ok) begin
							state_q <= S_STAMP;
						end else begin
							state_q <= S_RESULT;
						end
					end
				end
				S_READ: begin
					state_q <= S_RESULT;
				end
				S_STAMP: begin
					seen_q[item_q.channel] <= 1'b1;
					hit_cnt_q <= sat_inc(hit_cnt_q);
					state_q <= S_DIFF;
				end
				S_DIFF: begin
					if (seen_hit_q && t_lt) begin
						wrap_cnt_q <= sat_inc(wrap_cnt_q);
					end
					if (seen_hit_q && (item_q.event_id != prev_evt_q)) begin
						bit_q   <= QBIT_W'(QUOT_W - 1);
						state_q <= S_DIV;
					end else begin
						state_q <= S_RESULT;
					end
				end
				S_DIV: begin
					if (bit_q == '0) begin
						state_q <= S_HRD;
					end else begin
						bit_q <= bit_q - 1'b1;
					end
				end
				S_HRD: begin
					state_q <= S_HWR;
				end
				S_HWR: begin
					state_q <= S_RESULT;
				end
				S_RESULT: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: begin
					state_q <= S_IDLE;
				end
			endcase
		end
	end

	// datapath
	always_ff @(posedge clk) begin
		case (state_q)
			S_IDLE: begin
				if (accept) begin
					item_q    <= in_word;
					rd_ok_q   <= rbin_ok;
					ivl_q     <= '0;
					valid_q   <= 1'b0;
					filled_q  <= 1'b0;
					wrapped_q <= 1'b0;
					count_q   <= '0;
				end
			end
			S_READ: begin
				count_q <= rd_ok_q ? hist_rdata : '0;
			end
			S_STAMP: begin
				t_q        <= t_new;
				prev_t_q   <= chan_rdata[CHAN_W-1:EVT_W];
				prev_evt_q <= chan_rdata[EVT_W-1:0];
				seen_hit_q <= seen_q[item_q.channel];
			end
			S_DIFF: begin
				if (seen_hit_q) begin
					valid_q   <= 1'b1;
					ivl_q     <= ivl_new;
					wrapped_q <= t_lt;
				end
				if (seen_hit_q && (item_q.event_id != prev_evt_q)) begin
					filled_q <= 1'b1;
					rem_q    <= ivl_new;
					quot_q   <= '0;
				end
			end
			S_DIV: begin
				if (!trial[TIME_W]) begin
					rem_q         <= trial[TIME_W-1:0];
					quot_q[bit_q] <= 1'b1;
				end
			end
			S_HRD: begin
				bin_q <= bin_addr;
			end
			S_RESULT: begin
				if (out_free) begin
					out_word_q.interval_ns    <= ivl_q;
					out_word_q.interval_valid <= valid_q;
					out_word_q.filled         <= filled_q;
					out_word_q.wrapped        <= wrapped_q;
					out_word_q.bin_count      <= count_q;
					out_word_q.hit_total      <= hit_cnt_q;
					out_word_q.wrap_total     <= wrap_cnt_q;
				end
			end
			default: ;
		endcase
	end

	assign out_valid = out_valid_q;
	assign out_word  = out_word_q;

endmodule

`default_nettype wire
